// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (reset is active low).
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/nrm_pkg.sv =====
package nrm_pkg;

  // Default sizes.
  localparam int DEF_NUM_STATES       = 64;
  localparam int DEF_SLOTS_PER_STATE  = 2;
  localparam int DEF_RANGES_PER_CLASS = 4;

  // Input actions.
  localparam logic [1:0] ACT_LOAD_TRANS  = 2'd0;
  localparam logic [1:0] ACT_LOAD_RANGE  = 2'd1;
  localparam logic [1:0] ACT_MATCH_BYTE  = 2'd2;
  localparam logic [1:0] ACT_MATCH_EMPTY = 2'd3;

  // Transition kinds. The remaining code is stored as given and acts as unused.
  localparam logic [2:0] KIND_UNUSED  = 3'd0;
  localparam logic [2:0] KIND_EPSILON = 3'd1;
  localparam logic [2:0] KIND_LITERAL = 3'd2;
  localparam logic [2:0] KIND_ANY     = 3'd3;
  localparam logic [2:0] KIND_CLASS   = 3'd4;
  localparam logic [2:0] KIND_START   = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_STATE_COUNT  = 2'd0;
  localparam logic [1:0] REG_START_STATE  = 2'd1;
  localparam logic [1:0] REG_ACCEPT_STATE = 2'd2;

  // One transition slot as held in the transition memory.
  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] target;
    logic [7:0] lit;
    logic       neg;
    logic [5:0] nranges;
  } trans_ent_t;

endpackage

// ===== src/nfa_regex_matcher_core.sv =====
// Load items are written in the idle state. Match words walk the live states in passes: an
// inactive state is skipped, each slot of an active one is read, and in a move each class
// range is tested in turn. A move pass is followed by closure passes, repeated until
// one adds no state; a word that ends the string then gives a result. One word at a time.
// Synchronous active-low reset; afterwards a pass clears the transition memory while
// in_stall stays high.
module nfa_regex_matcher_core
  import nrm_pkg::*;
#(
  parameter int NUM_STATES       = DEF_NUM_STATES,
  parameter int SLOTS_PER_STATE  = DEF_SLOTS_PER_STATE,
  parameter int RANGES_PER_CLASS = DEF_RANGES_PER_CLASS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_symbol,
  input  logic        in_is_last,
  input  logic [5:0]  in_state_index,
  input  logic        in_slot_index,
  input  logic [2:0]  in_trans_kind,
  input  logic [5:0]  in_target_state,
  input  logic        in_class_negated,
  input  logic [2:0]  in_range_count,
  input  logic [1:0]  in_range_index,
  input  logic [7:0]  in_range_low,
  input  logic [7:0]  in_range_high,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Widths that follow from the sizes. The compare width is wide enough for a state
  // count one beyond the last index and for the 7-bit configured count.
  localparam int SW      = $clog2(NUM_STATES);
  localparam int CW      = (SW + 1 > 7) ? SW + 1 : 7;
  localparam int KW      = $clog2(SLOTS_PER_STATE);
  localparam int RW      = (RANGES_PER_CLASS > 1) ? $clog2(RANGES_PER_CLASS) : 1;
  localparam int T_DEPTH = NUM_STATES * SLOTS_PER_STATE;
  localparam int R_DEPTH = T_DEPTH * RANGES_PER_CLASS;
  localparam int TAW     = $clog2(T_DEPTH);
  localparam int RAW     = (R_DEPTH > T_DEPTH) ? $clog2(R_DEPTH) : TAW;
  localparam int TEW     = $bits(trans_ent_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_EVAL,
    S_RWAIT,
    S_RCHK,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic [TAW-1:0]          clr_r;
  logic [6:0]              state_count_r;
  logic [5:0]              start_r;
  logic [5:0]              accept_r;
  logic [NUM_STATES-1:0]   active_r;
  logic [NUM_STATES-1:0]   next_r;
  logic [CW-1:0]           st_r;
  logic [KW-1:0]           ks_r;
  logic [RW-1:0]           rcnt_r;
  logic                    closure_r;     // 1 while running closure passes, 0 for the move
  logic                    at_start_r;
  logic                    at_end_r;
  logic                    changed_r;
  logic                    then_step_r;   // a move follows the closure of the start set
  logic                    report_r;      // the current word ends the string
  logic                    last_r;
  logic [7:0]              sym_r;
  logic                    fresh_r;
  logic                    out_valid_r;
  logic                    matched_r;

  // Transition and class range memories, with registered reads.
  logic [TEW-1:0]          tmem [T_DEPTH];
  logic [15:0]             rmem [R_DEPTH];
  logic [TEW-1:0]          trd_r;
  logic [15:0]             rrd_r;

  // Memory addressing: the read side always follows the walk counters, the write side
  // serves loads and the clearing pass. Both never run at the same time.
  logic [CW-1:0]           live_n;
  logic [TAW-1:0]          taddr;
  logic [RAW-1:0]          raddr;
  logic [TAW-1:0]          lt_addr;
  logic [RAW-1:0]          lr_addr;
  logic                    load_tr;
  logic                    load_rg;
  logic                    t_we;
  logic [TAW-1:0]          t_waddr;
  trans_ent_t              t_wdata;
  logic [5:0]              rc_sat;

  trans_ent_t              ent;
  logic [CW-1:0]           tgt_ext;
  logic [SW-1:0]           tgt_idx;
  logic                    tgt_ok;
  logic [SW-1:0]           st_idx;
  logic                    st_live;
  logic                    last_slot;
  logic                    follow;
  logic                    simple_hit;
  logic                    class_walk;
  logic                    in_range;
  logic                    more_ranges;
  logic                    adv;
  logic                    set_next;
  logic                    set_act;
  logic [NUM_STATES-1:0]   start_set;
  logic [CW-1:0]           start_ext;
  logic [CW-1:0]           accept_ext;
  logic                    acc_hit;
  logic                    accept_in;
  logic                    cfg_wr;

  assign live_n = (CW'(state_count_r) > CW'(NUM_STATES)) ? CW'(NUM_STATES)
                                                         : CW'(state_count_r);

  assign st_idx  = st_r[SW-1:0];
  assign st_live = st_r < live_n;
  assign taddr   = TAW'(32'(st_idx) * SLOTS_PER_STATE + 32'(ks_r));
  assign raddr   = RAW'(32'(taddr) * RANGES_PER_CLASS + 32'(rcnt_r));

  assign lt_addr = TAW'(32'(in_state_index) * SLOTS_PER_STATE + 32'(in_slot_index));
  assign lr_addr = RAW'(32'(lt_addr) * RANGES_PER_CLASS + 32'(in_range_index));

  assign accept_in = (state_r == S_IDLE) && in_valid;
  assign load_tr   = accept_in && (in_action == ACT_LOAD_TRANS) &&
                     (32'(in_state_index) < 32'(NUM_STATES)) &&
                     (32'(in_slot_index) < 32'(SLOTS_PER_STATE));
  assign load_rg   = accept_in && (in_action == ACT_LOAD_RANGE) &&
                     (32'(in_state_index) < 32'(NUM_STATES)) &&
                     (32'(in_slot_index) < 32'(SLOTS_PER_STATE)) &&
                     (32'(in_range_index) < 32'(RANGES_PER_CLASS));

  // A range count beyond the class size saturates.
  assign rc_sat = (32'(in_range_count) > 32'(RANGES_PER_CLASS)) ? 6'(RANGES_PER_CLASS)
                                                                 : 6'(in_range_count);

  always_comb begin
    t_wdata = '0;
    if (state_r == S_CLEAR) begin
      t_we    = 1'b1;
      t_waddr = clr_r;
    end else begin
      t_we            = load_tr;
      t_waddr         = lt_addr;
      t_wdata.kind    = in_trans_kind;
      t_wdata.target  = in_target_state;
      t_wdata.lit     = in_symbol;
      t_wdata.neg     = in_class_negated;
      t_wdata.nranges = rc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    trd_r <= tmem[taddr];
  end

  always_ff @(posedge clk) begin
    if (load_rg) begin
      rmem[lr_addr] <= {in_range_high, in_range_low};
    end
    rrd_r <= rmem[raddr];
  end

  // Decode of the slot that the walk currently points at.
  assign ent       = trans_ent_t'(trd_r);
  assign tgt_ext   = CW'(ent.target);
  assign tgt_idx   = tgt_ext[SW-1:0];
  assign tgt_ok    = tgt_ext < live_n;
  assign last_slot = (ks_r == KW'(SLOTS_PER_STATE - 1));

  assign follow = (ent.kind == KIND_EPSILON) ||
                  ((ent.kind == KIND_START) && at_start_r) ||
                  ((ent.kind == KIND_END) && at_end_r);

  // An empty class needs no range reads: it matches every byte exactly when negated.
  assign class_walk = (ent.kind == KIND_CLASS) && (ent.nranges != 6'd0);
  assign simple_hit = ((ent.kind == KIND_LITERAL) && (ent.lit == sym_r)) ||
                      (ent.kind == KIND_ANY) ||
                      ((ent.kind == KIND_CLASS) && (ent.nranges == 6'd0) && ent.neg);

  assign in_range    = (sym_r >= rrd_r[7:0]) && (sym_r <= rrd_r[15:8]);
  assign more_ranges = (32'(rcnt_r) + 32'd1) < 32'(ent.nranges);

  // The walk moves on to the next slot once the current one is fully decided.
  assign adv = ((state_r == S_EVAL) && (closure_r || !class_walk)) ||
               ((state_r == S_RCHK) && (in_range || !more_ranges));

  assign set_next = tgt_ok && !closure_r &&
                    (((state_r == S_EVAL) && simple_hit) ||
                     ((state_r == S_RCHK) && in_range && !ent.neg) ||
                     ((state_r == S_RCHK) && !in_range && !more_ranges && ent.neg));

  assign set_act = (state_r == S_EVAL) && closure_r && follow && tgt_ok &&
                   !active_r[tgt_idx];

  assign start_ext  = CW'(start_r);
  assign accept_ext = CW'(accept_r);

  always_comb begin
    start_set = '0;
    if (start_ext < live_n) begin
      start_set[start_ext[SW-1:0]] = 1'b1;
    end
  end

  assign acc_hit = (accept_ext < live_n) && active_r[accept_ext[SW-1:0]];

  // Configuration port. Writes are taken on the access phase.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_STATE_COUNT:  prdata = 32'(state_count_r);
      REG_START_STATE:  prdata = 32'(start_r);
      REG_ACCEPT_STATE: prdata = 32'(accept_r);
      default:          prdata = '0;
    endcase
  end

  // Sequencer. A word either loads a memory entry in the idle state, or starts a walk.
  // A walk is a series of passes over the live states; inactive states are skipped,
  // active ones read each slot and, for classes in the move pass, each range in turn. The
  // move pass fills next_r, and closure passes add states to active_r until one pass
  // adds nothing, which is the same set a depth-first epsilon closure would reach.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      state_count_r <= 7'd1;
      start_r       <= '0;
      accept_r      <= '0;
      active_r      <= '0;
      next_r        <= '0;
      st_r          <= '0;
      ks_r          <= '0;
      rcnt_r        <= '0;
      closure_r     <= 1'b0;
      at_start_r    <= 1'b0;
      at_end_r      <= 1'b0;
      changed_r     <= 1'b0;
      then_step_r   <= 1'b0;
      report_r      <= 1'b0;
      last_r        <= 1'b0;
      fresh_r       <= 1'b1;
      out_valid_r   <= 1'b0;
      matched_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_STATE_COUNT:  state_count_r <= pwdata[6:0];
          REG_START_STATE:  start_r       <= pwdata[5:0];
          REG_ACCEPT_STATE: accept_r      <= pwdata[5:0];
          default: ;
        endcase
      end

      if (set_next) begin
        next_r[tgt_idx] <= 1'b1;
      end
      if (set_act) begin
        active_r[tgt_idx] <= 1'b1;
        changed_r         <= 1'b1;
      end
      if (adv) begin
        state_r <= S_ISSUE;
        if (last_slot) begin
          st_r <= st_r + CW'(1);
          ks_r <= '0;
        end else begin
          ks_r <= ks_r + KW'(1);
        end
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + TAW'(1);
          if (clr_r == TAW'(T_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            case (in_action)
              ACT_MATCH_BYTE: begin
                sym_r     <= in_symbol;
                last_r    <= in_is_last;
                report_r  <= in_is_last;
                st_r      <= '0;
                ks_r      <= '0;
                changed_r <= 1'b0;
                fresh_r   <= 1'b0;
                state_r   <= S_ISSUE;
                if (fresh_r) begin
                  // New string: close the start set first, then make the move.
                  active_r    <= start_set;
                  closure_r   <= 1'b1;
                  at_start_r  <= 1'b1;
                  at_end_r    <= 1'b0;
                  then_step_r <= 1'b1;
                end else begin
                  closure_r   <= 1'b0;
                  next_r      <= '0;
                  then_step_r <= 1'b0;
                end
              end
              ACT_MATCH_EMPTY: begin
                // Ends the string: follow end anchors from the current or start set.
                report_r    <= 1'b1;
                closure_r   <= 1'b1;
                at_end_r    <= 1'b1;
                then_step_r <= 1'b0;
                st_r        <= '0;
                ks_r        <= '0;
                changed_r   <= 1'b0;
                state_r     <= S_ISSUE;
                at_start_r  <= fresh_r;
                if (fresh_r) begin
                  active_r <= start_set;
                end
              end
              default: ;
            endcase
          end
        end

        S_ISSUE: begin
          if (!st_live) begin
            // End of a pass over the live states.
            if (!closure_r) begin
              active_r   <= next_r;
              closure_r  <= 1'b1;
              at_start_r <= 1'b0;
              at_end_r   <= last_r;
              changed_r  <= 1'b0;
              st_r       <= '0;
              ks_r       <= '0;
            end else if (changed_r) begin
              changed_r <= 1'b0;
              st_r      <= '0;
              ks_r      <= '0;
            end else if (then_step_r) begin
              then_step_r <= 1'b0;
              closure_r   <= 1'b0;
              next_r      <= '0;
              st_r        <= '0;
              ks_r        <= '0;
            end else if (report_r) begin
              out_valid_r <= 1'b1;
              matched_r   <= acc_hit;
              fresh_r     <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (!active_r[st_idx]) begin
            st_r <= st_r + CW'(1);
            ks_r <= '0;
          end else begin
            state_r <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (!closure_r && class_walk) begin
            rcnt_r  <= '0;
            state_r <= S_RWAIT;
          end
        end

        S_RWAIT: begin
          state_r <= S_RCHK;
        end

        S_RCHK: begin
          if (!in_range && more_ranges) begin
            rcnt_r  <= rcnt_r + RW'(1);
            state_r <= S_RWAIT;
          end
        end

        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_matched = matched_r;

endmodule

// ===== src/nrm_checker.sv =====
`include "assert_macros.svh"

module nrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_matched
);

  // A held result keeps its value until it is taken.
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_matched), "result changed while stalled")

  // No new word is taken while a result waits.
  `ASSERT_CLK_RST(a_busy_while_out, clk, rst_n, out_valid |-> in_stall, "input accepted while a result is pending")

  // After reset the block is clearing its memory and has no result.
  `ASSERT_CLK(a_reset_state, clk, !rst_n |=> in_stall && !out_valid, "bad state after reset")

  // A result only appears after a word was accepted while idle.
  `ASSERT_CLK_RST(a_out_cause, clk, rst_n, $rose(out_valid) |-> in_stall && $past(in_stall), "result without an accepted word")

endmodule

bind nfa_regex_matcher_core nrm_checker u_nrm_checker (.*);

// ===== tb/sv/nfa_regex_matcher_core_tb.sv =====
module nfa_regex_matcher_core_tb;
  import nrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One input word as it is offered on the input channel, one field per port.
  typedef struct {
    logic [1:0] action;
    logic [7:0] symbol;
    logic       is_last;
    logic [5:0] state_index;
    logic       slot_index;
    logic [2:0] trans_kind;
    logic [5:0] target_state;
    logic       class_negated;
    logic [2:0] range_count;
    logic [1:0] range_index;
    logic [7:0] range_low;
    logic [7:0] range_high;
  } word_t;

  // The scoreboard keeps its own copy of the NFA tables, the active state set and the
  // register values. Every accepted word is run through it, and each string that ends
  // leaves one expected match bit in the queue.
  class nfa_scoreboard;
    trans_ent_t  slot_tab[64][2];
    logic [7:0]  lo_tab[64][2][4];
    logic [7:0]  hi_tab[64][2][4];
    bit   [63:0] live_set;
    bit          fresh;
    int unsigned n_states;
    int unsigned start_idx;
    int unsigned accept_idx;
    bit          match_q[$];
    int          errors;

    function new();
      foreach (slot_tab[s, k]) slot_tab[s][k] = '0;
      foreach (lo_tab[s, k, r]) begin
        lo_tab[s][k][r] = '0;
        hi_tab[s][k][r] = '0;
      end
      live_set = '0;
      fresh = 1'b1;
      n_states = 1;
      start_idx = 0;
      accept_idx = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned value);
      case (idx)
        REG_STATE_COUNT: n_states = value & 32'h7f;
        REG_START_STATE: start_idx = value & 32'h3f;
        REG_ACCEPT_STATE: accept_idx = value & 32'h3f;
        default: ;
      endcase
    endfunction

    function int unsigned live();
      return (n_states > 64) ? 64 : n_states;
    endfunction

    function bit byte_hits(int s, int k, logic [7:0] c);
      trans_ent_t t;
      bit in_class;
      t = slot_tab[s][k];
      in_class = 1'b0;
      case (t.kind)
        KIND_LITERAL: return t.lit == c;
        KIND_ANY: return 1'b1;
        KIND_CLASS: begin
          for (int r = 0; r < t.nranges && r < 4; r++)
            if (c >= lo_tab[s][k][r] && c <= hi_tab[s][k][r]) in_class = 1'b1;
          return t.neg ? !in_class : in_class;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Epsilon closure over the live states; anchors are followed only when allowed.
    function void close_set(bit at_start, bit at_end);
      int stk[$];
      int n;
      int s;
      bit follow;
      trans_ent_t t;
      n = live();
      for (int i = 0; i < n; i++)
        if (live_set[i]) stk.push_back(i);
      while (stk.size() > 0) begin
        s = stk.pop_back();
        for (int k = 0; k < 2; k++) begin
          t = slot_tab[s][k];
          follow = (t.kind == KIND_EPSILON) || (t.kind == KIND_START && at_start) ||
                   (t.kind == KIND_END && at_end);
          if (follow && t.target < n && !live_set[t.target]) begin
            live_set[t.target] = 1'b1;
            stk.push_back(t.target);
          end
        end
      end
    endfunction

    function void arm(bit at_end);
      live_set = '0;
      if (start_idx < live()) live_set[start_idx] = 1'b1;
      close_set(1'b1, at_end);
    endfunction

    function void move_on(logic [7:0] c);
      bit [63:0] nxt;
      int n;
      nxt = '0;
      n = live();
      for (int i = 0; i < n; i++)
        if (live_set[i])
          for (int k = 0; k < 2; k++)
            if (byte_hits(i, k, c) && slot_tab[i][k].target < n)
              nxt[slot_tab[i][k].target] = 1'b1;
      live_set = nxt;
    endfunction

    function void end_string();
      match_q.push_back(accept_idx < live() && live_set[accept_idx]);
      fresh = 1'b1;
    endfunction

    function void note_word(word_t w);
      case (w.action)
        ACT_LOAD_TRANS: begin
          slot_tab[w.state_index][w.slot_index].kind = w.trans_kind;
          slot_tab[w.state_index][w.slot_index].target = w.target_state;
          slot_tab[w.state_index][w.slot_index].lit = w.symbol;
          slot_tab[w.state_index][w.slot_index].neg = w.class_negated;
          slot_tab[w.state_index][w.slot_index].nranges =
            (w.range_count > 4) ? 6'd4 : 6'(w.range_count);
        end
        ACT_LOAD_RANGE: begin
          lo_tab[w.state_index][w.slot_index][w.range_index] = w.range_low;
          hi_tab[w.state_index][w.slot_index][w.range_index] = w.range_high;
        end
        ACT_MATCH_BYTE: begin
          if (fresh) arm(1'b0);
          fresh = 1'b0;
          move_on(w.symbol);
          close_set(1'b0, w.is_last);
          if (w.is_last) end_string();
        end
        default: begin
          if (fresh) arm(1'b1);
          else close_set(1'b0, 1'b1);
          end_string();
        end
      endcase
    endfunction

    function void check_result(logic got);
      bit want;
      if (match_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result word with no string ended, matched=%b",
                                   $realtime, got);
        return;
      end
      want = match_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("%0t: matched mismatch, expected %b got %b",
                                   $realtime, want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  word_t       w_drv;
  logic        out_valid;
  logic        out_stall;
  logic        out_matched;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nfa_regex_matcher_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(w_drv.action), .in_symbol(w_drv.symbol), .in_is_last(w_drv.is_last),
    .in_state_index(w_drv.state_index), .in_slot_index(w_drv.slot_index),
    .in_trans_kind(w_drv.trans_kind), .in_target_state(w_drv.target_state),
    .in_class_negated(w_drv.class_negated), .in_range_count(w_drv.range_count),
    .in_range_index(w_drv.range_index), .in_range_low(w_drv.range_low),
    .in_range_high(w_drv.range_high),
    .out_valid(out_valid), .out_stall(out_stall), .out_matched(out_matched),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  nfa_scoreboard sb;
  bit            quiet_phase;  // when set, neither side inserts idle cycles
  bit            hold_req;     // asks the receiver for one long stall stretch
  bit [7:0]      alphabet[4];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Fixed upper bound on the run. Byte words on large NFAs take the longest, so this
  // is kept far above the slowest legal run.
  initial begin
    #200ms;
    $display("FAIL nfa_regex_matcher_core");
    $finish;
  end

  // Every accepted result word is checked at the rising edge on which it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_matched);
  end

  // Receiver side: stalls a random number of cycles before each result word, and once
  // on request holds off for a long stretch so that the block backs up into its input.
  initial begin
    int unsigned wait_cycles;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
      end
      wait_cycles = quiet_phase ? 0 : $urandom_range(0, 13);
      out_stall = (wait_cycles != 0);
      repeat (wait_cycles) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one word, waits until the block takes it, then idles for a random gap.
  task automatic send_word(word_t w);
    int unsigned gap;
    w_drv = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    @(negedge clk);
    gap = quiet_phase ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Returns the input channel to idle, used before register writes and pauses.
  task automatic park_input();
    in_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, int unsigned value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Waits until every ended string has reported, then lets the block settle.
  task automatic drain();
    park_input();
    while (sb.match_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Every field random, so unused fields toggle all their bits as well.
  function automatic word_t noise_word();
    word_t w;
    w.action = 2'($urandom);
    w.symbol = 8'($urandom);
    w.is_last = 1'($urandom);
    w.state_index = 6'($urandom);
    w.slot_index = 1'($urandom);
    w.trans_kind = 3'($urandom);
    w.target_state = 6'($urandom);
    w.class_negated = 1'($urandom);
    w.range_count = 3'($urandom);
    w.range_index = 2'($urandom);
    w.range_low = 8'($urandom);
    w.range_high = 8'($urandom);
    return w;
  endfunction

  task automatic load_slot(int s, int k, logic [2:0] kind, int tgt, logic [7:0] lit);
    word_t w;
    w = noise_word();
    w.action = ACT_LOAD_TRANS;
    w.state_index = 6'(s);
    w.slot_index = 1'(k);
    w.trans_kind = kind;
    w.target_state = 6'(tgt);
    w.symbol = lit;
    send_word(w);
  endtask

  task automatic load_range(int s, int k, int r, logic [7:0] lo, logic [7:0] hi);
    word_t w;
    w = noise_word();
    w.action = ACT_LOAD_RANGE;
    w.state_index = 6'(s);
    w.slot_index = 1'(k);
    w.range_index = 2'(r);
    w.range_low = lo;
    w.range_high = hi;
    send_word(w);
  endtask

  task automatic send_byte(logic [7:0] c, bit last);
    word_t w;
    w = noise_word();
    w.action = ACT_MATCH_BYTE;
    w.symbol = c;
    w.is_last = last;
    send_word(w);
  endtask

  task automatic send_empty();
    word_t w;
    w = noise_word();
    w.action = ACT_MATCH_EMPTY;
    send_word(w);
  endtask

  task automatic send_string(string str);
    if (str.len() == 0) send_empty();
    for (int i = 0; i < str.len(); i++) send_byte(str[i], i == str.len() - 1);
  endtask

  // Random NFA over the live states, mostly with targets in range and literals from a
  // small alphabet, so that strings actually travel through the graph.
  task automatic build_nfa(int n);
    logic [2:0] kind;
    int tgt;
    for (int s = 0; s < n && s < 64; s++)
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 11))
          0, 1: kind = KIND_EPSILON;
          2, 3, 4: kind = KIND_LITERAL;
          5: kind = KIND_ANY;
          6, 7: kind = KIND_CLASS;
          8: kind = KIND_START;
          9: kind = KIND_END;
          10: kind = KIND_UNUSED;
          default: kind = 3'd7;
        endcase
        tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        load_slot(s, k, kind, tgt, ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                  alphabet[$urandom_range(0, 3)]);
      end
    if ($urandom_range(0, 1)) load_range($urandom_range(0, 63), $urandom, $urandom,
                                         alphabet[0], alphabet[$urandom_range(0, 3)]);
  endtask

  // A run of strings over the alphabet; now and then an empty word cuts one short or
  // a random word lands inside a string. The run always ends on a closed string.
  task automatic match_strings(int count);
    int len;
    for (int i = 0; i < count; i++) begin
      len = $urandom_range(0, 6);
      if (len == 0) send_empty();
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_empty();
          break;
        end
        if ($urandom_range(0, 29) == 0) send_word(noise_word());
        send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 3)],
                  j == len - 1);
      end
    end
    send_empty();
  endtask

  initial begin
    int n;
    sb = new();
    quiet_phase = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    w_drv = '{default: '0};
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Write every class range once so that no class ever reads an unwritten range.
    foreach (sb.lo_tab[s, k, r]) load_range(s, k, r, 8'($urandom), 8'($urandom));

    // Directed: a start anchor, literal 'a' and an end anchor in a chain, so that only
    // the string "a" matches; then the empty string, bytes at both ends of the range,
    // an anchored accept through an empty word, and a class slot with a random range count.
    drain();
    reg_write(REG_STATE_COUNT, 4);
    reg_write(REG_START_STATE, 0);
    reg_write(REG_ACCEPT_STATE, 3);
    load_slot(0, 0, KIND_START, 1, 8'h00);
    load_slot(1, 0, KIND_LITERAL, 2, "a");
    load_slot(2, 0, KIND_END, 3, 8'hff);
    load_slot(63, 1, 3'd7, 63, 8'hff);
    send_string("");
    send_string("a");
    send_string("aa");
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte("a", 1'b0);
    send_empty();
    load_slot(1, 1, KIND_CLASS, 2, 8'h00);
    send_byte(8'h55, 1'b1);
    drain();
    // Accept outside the live states, then no states at all, then the widest count.
    reg_write(REG_ACCEPT_STATE, 63);
    send_string("a");
    drain();
    reg_write(REG_STATE_COUNT, 0);
    send_string("a");
    drain();
    reg_write(REG_STATE_COUNT, 127);
    reg_write(REG_START_STATE, 63);
    send_string("");
    send_byte(8'h00, 1'b1);
    drain();

    for (int phase = 0; phase < 26; phase++) begin
      quiet_phase = (phase % 5 == 3);
      for (int i = 0; i < 4; i++) alphabet[i] = (phase % 4 == 0) ? 8'($urandom) : 8'("a" + i);
      case (phase)
        6: n = 64;
        11: n = 0;
        17: n = 127;
        default: n = $urandom_range(2, 12);
      endcase
      reg_write(REG_STATE_COUNT, n);
      reg_write(REG_START_STATE, ($urandom_range(0, 7) == 0 || n == 0) ? $urandom_range(0, 63) :
                $urandom_range(0, (n > 64 ? 64 : n) - 1));
      reg_write(REG_ACCEPT_STATE, ($urandom_range(0, 7) == 0 || n == 0) ? $urandom_range(0, 63) :
                $urandom_range(0, (n > 64 ? 64 : n) - 1));
      build_nfa((n > 64) ? 64 : ((n < 2) ? 2 : n));
      if (phase == 4) hold_req = 1'b1;
      match_strings((n > 16) ? 4 : 12);
      if (phase == 8) begin
        drain();
        match_strings(6);
      end
      drain();
    end

    if (sb.errors == 0 && sb.match_q.size() == 0) begin
      $display("PASS nfa_regex_matcher_core");
    end else begin
      $display("FAIL nfa_regex_matcher_core");
    end
    $finish;
  end

endmodule
